### src/ds8b_pkg.sv
package ds8b_pkg;

  // Field and storage sizes.
  localparam int unsigned IndexBits    = 32;
  localparam int unsigned DeltaBits    = IndexBits + 1;
  localparam int unsigned PayloadBits  = 60;
  localparam int unsigned MaxDeltas    = 60;
  localparam int unsigned CountBits    = 6;
  localparam int unsigned AddrBits     = $clog2(MaxDeltas);
  localparam int unsigned UsedBits     = 6;
  localparam int unsigned SelBits      = 4;
  localparam int unsigned TotalBits    = 21;
  localparam int unsigned TotalLimit   = 1048576;
  localparam int unsigned InTdataBits  = 32;
  localparam int unsigned OutFieldBits = PayloadBits + CountBits + 2 * TotalBits;
  localparam int unsigned OutTdataBits = ((OutFieldBits + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture an input transaction and form its delta
    logic write;       // append the delta to the buffer
    logic pack_start;  // clear the packing accumulator
    logic pack_run;    // step the packing sweep
    logic emit;        // load the packed word into the output register
    logic emit_final;  // the emitted word closes the column
  } ds8b_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flush_need;  // the new delta does not fit into the buffered word
    logic last;        // the current index closes the column
    logic pack_done;   // all buffered deltas are in the accumulator
    logic out_free;    // the output register can take a word this cycle
  } ds8b_sts_t;

  // Number of significant bits of a delta.
  function automatic logic [UsedBits-1:0] bit_len(input logic [DeltaBits-1:0] v);
    logic [UsedBits-1:0] n;
    n = '0;
    for (int i = 0; i < DeltaBits; i++) begin
      if (v[i]) begin
        n = UsedBits'(i + 1);
      end
    end
    return n;
  endfunction

  // Bits per slot in a word holding n deltas (payload divided by n).
  function automatic logic [UsedBits-1:0] slot_width(input logic [CountBits:0] n);
    logic [UsedBits-1:0] w;
    if (n <= 7'd1) w = 6'd60;
    else if (n == 7'd2) w = 6'd30;
    else if (n == 7'd3) w = 6'd20;
    else if (n == 7'd4) w = 6'd15;
    else if (n == 7'd5) w = 6'd12;
    else if (n == 7'd6) w = 6'd10;
    else if (n == 7'd7) w = 6'd8;
    else if (n == 7'd8) w = 6'd7;
    else if (n <= 7'd10) w = 6'd6;
    else if (n <= 7'd12) w = 6'd5;
    else if (n <= 7'd15) w = 6'd4;
    else if (n <= 7'd20) w = 6'd3;
    else if (n <= 7'd30) w = 6'd2;
    else w = 6'd1;
    return w;
  endfunction

  // Standard Simple-8b selector for a word holding n deltas.
  function automatic logic [SelBits-1:0] selector_for(input logic [CountBits-1:0] n);
    logic [SelBits-1:0] s;
    if (n <= 6'd1) s = 4'd15;
    else if (n <= 6'd8) s = SelBits'(7'd16 - {1'b0, n});
    else if (n <= 6'd10) s = 4'd7;
    else if (n <= 6'd12) s = 4'd6;
    else if (n <= 6'd15) s = 4'd5;
    else if (n <= 6'd20) s = 4'd4;
    else if (n <= 6'd30) s = 4'd3;
    else s = 4'd2;
    return s;
  endfunction

endpackage

### src/delta_simple8b_index_packer.sv
// Channel   Dir  Transaction          Fields (lowest bit first)
// s_axis    in   one column index     tdata: column_index; tlast: last_index
// m_axis    out  one Simple-8b word   tdata: payload, deltas_in_word, entry_total,
//                                     word_total; tuser: selector_code; tlast: last_word
//
// An index that fits into the buffered word is accepted, then evaluated and appended.
// A flush of a word with n deltas sweeps the n entries over the one read port of the delta
// buffer RAM before the append; a closing word is packed by the same sweep after the append.
// Reset clears the column state; no clearing pass is needed, only written entries are read.
// One output register holds a finished word; the next index is accepted while it waits,
// and the block stalls only when a second word is ready before the first was taken.
module delta_simple8b_index_packer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ds8b_pkg::InTdataBits-1:0]    s_axis_tdata,   // column_index
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ds8b_pkg::OutTdataBits-1:0]   m_axis_tdata,   // payload, deltas_in_word,
                                                              // entry_total, word_total, zeros
  output logic [ds8b_pkg::SelBits-1:0]        m_axis_tuser,   // selector_code
  output logic                                m_axis_tlast
);

  import ds8b_pkg::*;

  ds8b_cmd_t              cmd;
  ds8b_sts_t              sts;
  logic [SelBits-1:0]     selector_code;
  logic [PayloadBits-1:0] payload;
  logic [CountBits-1:0]   deltas_in_word;
  logic [TotalBits-1:0]   entry_total;
  logic [TotalBits-1:0]   word_total;

  // Sequencer.
  ds8b_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Delta, buffer, packing and output register.
  ds8b_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .column_index_i   (s_axis_tdata[IndexBits-1:0]),
    .last_index_i     (s_axis_tlast),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .m_ready_i        (m_axis_tready),
    .m_valid_o        (m_axis_tvalid),
    .selector_code_o  (selector_code),
    .payload_o        (payload),
    .deltas_in_word_o (deltas_in_word),
    .last_word_o      (m_axis_tlast),
    .entry_total_o    (entry_total),
    .word_total_o     (word_total)
  );

  // Output fields packed from the lowest bit up.
  assign m_axis_tdata = {{(OutTdataBits-OutFieldBits){1'b0}},
                         word_total, entry_total, deltas_in_word, payload};
  assign m_axis_tuser = selector_code;

endmodule

### src/ds8b_ram.sv
module ds8b_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ds8b_ctrl.sv
module ds8b_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  ds8b_pkg::ds8b_sts_t sts_i,
  output ds8b_pkg::ds8b_cmd_t cmd_o
);

  import ds8b_pkg::*;

  localparam logic [2:0] StIdle      = 3'd0;
  localparam logic [2:0] StEval      = 3'd1;
  localparam logic [2:0] StWrite     = 3'd2;
  localparam logic [2:0] StFlushPack = 3'd3;
  localparam logic [2:0] StFlushEmit = 3'd4;
  localparam logic [2:0] StLastPack  = 3'd5;
  localparam logic [2:0] StLastEmit  = 3'd6;

  logic [2:0] state_d, state_q;

  // Sequence of one index: accept, evaluate, optional flush, write, optional final word.
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StEval;
        end
      end
      StEval: begin
        if (sts_i.flush_need) begin
          cmd_o.pack_start = 1'b1;
          state_d          = StFlushPack;
        end else begin
          cmd_o.write = 1'b1;
          if (sts_i.last) begin
            cmd_o.pack_start = 1'b1;
            state_d          = StLastPack;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StWrite: begin
        cmd_o.write = 1'b1;
        if (sts_i.last) begin
          cmd_o.pack_start = 1'b1;
          state_d          = StLastPack;
        end else begin
          state_d = StIdle;
        end
      end
      StFlushPack: begin
        cmd_o.pack_run = 1'b1;
        if (sts_i.pack_done) begin
          state_d = StFlushEmit;
        end
      end
      StFlushEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StWrite;
        end
      end
      StLastPack: begin
        cmd_o.pack_run = 1'b1;
        if (sts_i.pack_done) begin
          state_d = StLastEmit;
        end
      end
      StLastEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_final = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/ds8b_dpath.sv
module ds8b_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [ds8b_pkg::IndexBits-1:0]        column_index_i,
  input  logic                                  last_index_i,
  input  ds8b_pkg::ds8b_cmd_t                   cmd_i,
  output ds8b_pkg::ds8b_sts_t                   sts_o,
  input  logic                                  m_ready_i,
  output logic                                  m_valid_o,
  output logic [ds8b_pkg::SelBits-1:0]          selector_code_o,
  output logic [ds8b_pkg::PayloadBits-1:0]      payload_o,
  output logic [ds8b_pkg::CountBits-1:0]        deltas_in_word_o,
  output logic                                  last_word_o,
  output logic [ds8b_pkg::TotalBits-1:0]        entry_total_o,
  output logic [ds8b_pkg::TotalBits-1:0]        word_total_o
);

  import ds8b_pkg::*;

  // Column state.
  logic [DeltaBits-1:0]   prev_d, prev_q;
  logic [DeltaBits-1:0]   delta_d, delta_q;
  logic                   last_d, last_q;
  logic [CountBits-1:0]   count_d, count_q;
  logic [UsedBits-1:0]    widest_d, widest_q;
  logic [TotalBits-1:0]   entries_d, entries_q;
  logic [TotalBits-1:0]   words_d, words_q;

  // Packing sweep.
  logic [CountBits-1:0]   iss_d, iss_q;
  logic [CountBits-1:0]   got_d, got_q;
  logic                   pend_d, pend_q;
  logic [UsedBits-1:0]    sh_d, sh_q;
  logic [PayloadBits-1:0] acc_d, acc_q;

  // Output register.
  logic                   m_valid_d, m_valid_q;
  logic [SelBits-1:0]     sel_q;
  logic [PayloadBits-1:0] pay_q;
  logic [CountBits-1:0]   n_q;
  logic                   olast_q;
  logic [TotalBits-1:0]   etot_q, wtot_q;

  logic [DeltaBits:0]     diff;
  logic [UsedBits-1:0]    used;
  logic [UsedBits-1:0]    widest_new;
  logic [UsedBits-1:0]    limit;
  logic [UsedBits-1:0]    slot_w;
  logic [TotalBits-1:0]   words_inc;
  logic                   rd_en;
  logic [DeltaBits-1:0]   rdata;
  logic                   out_free;

  // Delta against the previous index; a non-increasing index gives zero.
  assign diff = {2'b00, column_index_i} - {prev_q[DeltaBits-1], prev_q};

  // Fit test of the buffered word with the new delta added.
  assign used       = bit_len(delta_q);
  assign widest_new = (used > widest_q) ? used : widest_q;
  assign limit      = slot_width({1'b0, count_q} + 7'd1);
  assign slot_w     = slot_width({1'b0, count_q});
  assign words_inc  = (words_q < TotalBits'(TotalLimit)) ? words_q + 1'b1 : words_q;
  assign rd_en      = cmd_i.pack_run && (iss_q < count_q);
  assign out_free   = !m_valid_q || m_ready_i;

  assign sts_o.flush_need = (count_q != '0) &&
                            ((count_q >= CountBits'(MaxDeltas)) || (widest_new > limit));
  assign sts_o.last       = last_q;
  assign sts_o.pack_done  = (got_q == count_q);
  assign sts_o.out_free   = out_free;

  // Delta buffer.
  ds8b_ram #(
    .Width (DeltaBits),
    .Depth (MaxDeltas)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (count_q[AddrBits-1:0]),
    .wdata_i (delta_q),
    .re_i    (rd_en),
    .raddr_i (iss_q[AddrBits-1:0]),
    .rdata_o (rdata)
  );

  // Next-state logic of column and packing state.
  always_comb begin
    prev_d    = prev_q;
    delta_d   = delta_q;
    last_d    = last_q;
    count_d   = count_q;
    widest_d  = widest_q;
    entries_d = entries_q;
    words_d   = words_q;
    iss_d     = iss_q;
    got_d     = got_q;
    pend_d    = pend_q;
    sh_d      = sh_q;
    acc_d     = acc_q;
    m_valid_d = m_valid_q;

    if (cmd_i.load) begin
      delta_d = (diff[DeltaBits] || (diff == '0)) ? '0 : diff[DeltaBits-1:0];
      prev_d  = last_index_i ? '1 : {1'b0, column_index_i};
      last_d  = last_index_i;
      if (entries_q < TotalBits'(TotalLimit)) begin
        entries_d = entries_q + 1'b1;
      end
    end

    if (cmd_i.write) begin
      count_d  = count_q + 1'b1;
      widest_d = widest_new;
    end

    if (cmd_i.pack_start) begin
      iss_d  = '0;
      got_d  = '0;
      pend_d = 1'b0;
      sh_d   = '0;
      acc_d  = '0;
    end else if (cmd_i.pack_run) begin
      pend_d = rd_en;
      if (rd_en) begin
        iss_d = iss_q + 1'b1;
      end
      if (pend_q) begin
        acc_d = acc_q | ({{(PayloadBits-DeltaBits){1'b0}}, rdata} << sh_q);
        sh_d  = sh_q + slot_w;
        got_d = got_q + 1'b1;
      end
    end

    if (cmd_i.emit) begin
      count_d   = '0;
      widest_d  = '0;
      m_valid_d = 1'b1;
      if (cmd_i.emit_final) begin
        words_d   = '0;
        entries_d = '0;
      end else begin
        words_d = words_inc;
      end
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '1;
      last_q    <= 1'b0;
      count_q   <= '0;
      widest_q  <= '0;
      entries_q <= '0;
      words_q   <= '0;
      iss_q     <= '0;
      got_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      prev_q    <= prev_d;
      last_q    <= last_d;
      count_q   <= count_d;
      widest_q  <= widest_d;
      entries_q <= entries_d;
      words_q   <= words_d;
      iss_q     <= iss_d;
      got_q     <= got_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    sh_q    <= sh_d;
    acc_q   <= acc_d;
    if (cmd_i.emit) begin
      sel_q   <= selector_for(count_q);
      pay_q   <= acc_q;
      n_q     <= count_q;
      olast_q <= cmd_i.emit_final;
      etot_q  <= cmd_i.emit_final ? entries_q : '0;
      wtot_q  <= cmd_i.emit_final ? words_inc : '0;
    end
  end

  assign m_valid_o        = m_valid_q;
  assign selector_code_o  = sel_q;
  assign payload_o        = pay_q;
  assign deltas_in_word_o = n_q;
  assign last_word_o      = olast_q;
  assign entry_total_o    = etot_q;
  assign word_total_o     = wtot_q;

  // The buffer never holds more deltas than a word can carry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(MaxDeltas))
    else $error("buffered delta count above word capacity");

  // A delta is only appended while the buffer has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> (count_q < CountBits'(MaxDeltas)))
    else $error("delta written into a full buffer");

  // A word is only loaded when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("output word overwritten before it was taken");

  // Every presented word carries at least one delta.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ((n_q != '0) && (n_q <= CountBits'(MaxDeltas))))
    else $error("emitted word with an invalid delta count");

  // The closing word of a column counts itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && olast_q) |-> (wtot_q != '0) && (etot_q != '0))
    else $error("closing word with a zero total");

endmodule

### dv/tb_delta_simple8b_index_packer.sv
`timescale 1ns / 1ps

module tb_delta_simple8b_index_packer;

  import ds8b_pkg::*;

  localparam int unsigned WordSlots = 60;
  localparam int unsigned SatLimit  = 1048576;

  // One Simple-8b word as it should leave the block.
  typedef struct {
    bit [3:0]  selector_code;
    bit [59:0] payload;
    bit [5:0]  deltas_in_word;
    bit        last_word;
    bit [20:0] entry_total;
    bit [20:0] word_total;
  } s8b_word_t;

  // Column packer model and the queue of words it predicts.
  class s8b_word_scoreboard;
    s8b_word_t   expected_words[$];
    int unsigned failures;
    longint      prev_index;
    bit [63:0]   delta_store[WordSlots];
    int unsigned delta_count;
    int unsigned widest_bits;
    int unsigned entry_count;
    int unsigned word_count;

    function new();
      failures    = 0;
      prev_index  = -1;
      delta_count = 0;
      widest_bits = 0;
      entry_count = 0;
      word_count  = 0;
    endfunction

    function int unsigned significant_bits(bit [63:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 64; i++) begin
        if (v[i]) begin
          n = i + 1;
        end
      end
      return n;
    endfunction

    function bit [3:0] simple8b_selector(int unsigned n);
      if (n <= 1) return 4'd15;
      if (n <= 8) return 4'(16 - n);
      if (n <= 10) return 4'd7;
      if (n <= 12) return 4'd6;
      if (n <= 15) return 4'd5;
      if (n <= 20) return 4'd4;
      if (n <= 30) return 4'd3;
      return 4'd2;
    endfunction

    // Pack the buffered deltas into one word and clear the buffer.
    function void close_word(bit is_last);
      s8b_word_t   w;
      int unsigned slot;
      bit [63:0]   packed_bits;
      slot = (delta_count == 0) ? 60 : 60 / delta_count;
      packed_bits = '0;
      for (int i = 0; i < delta_count; i++) begin
        if (i * slot < 64) begin
          packed_bits |= delta_store[i] << (i * slot);
        end
      end
      if (word_count < SatLimit) begin
        word_count++;
      end
      w.selector_code  = simple8b_selector(delta_count);
      w.payload        = packed_bits[59:0];
      w.deltas_in_word = 6'(delta_count);
      w.last_word      = is_last;
      w.entry_total    = is_last ? 21'(entry_count) : '0;
      w.word_total     = is_last ? 21'(word_count) : '0;
      expected_words.push_back(w);
      delta_count = 0;
      widest_bits = 0;
    endfunction

    // Account for one accepted index transaction.
    function void note_index(bit [31:0] column_index, bit last_index);
      longint      diff;
      bit [63:0]   delta;
      int unsigned used;
      int unsigned widest;
      diff = longint'({32'b0, column_index}) - prev_index;
      if (diff <= 0) begin
        delta = '0;
      end else if (diff > longint'(64'h0FFF_FFFF_FFFF_FFFF)) begin
        delta = 64'h0FFF_FFFF_FFFF_FFFF;
      end else begin
        delta = diff;
      end
      used = significant_bits(delta);
      if (entry_count < SatLimit) begin
        entry_count++;
      end
      widest = (used > widest_bits) ? used : widest_bits;
      // Flush when the buffer is full or the new delta would not fit.
      if (delta_count != 0 &&
          (delta_count >= WordSlots || widest > 60 / (delta_count + 1))) begin
        close_word(1'b0);
      end
      if (delta_count < WordSlots) begin
        delta_store[delta_count] = delta;
        delta_count++;
      end
      if (used > widest_bits) begin
        widest_bits = used;
      end
      prev_index = longint'({32'b0, column_index});
      if (last_index) begin
        close_word(1'b1);
        prev_index  = -1;
        entry_count = 0;
        word_count  = 0;
      end
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %0h, actual %0h", $time, name, exp_v, act_v);
        failures++;
      end
    endfunction

    // Compare one accepted output word with the oldest prediction.
    function void check_word(logic [OutTdataBits-1:0] tdata, logic [3:0] tuser,
                             logic tlast);
      s8b_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual tdata %0h", $time, tdata);
        failures++;
        return;
      end
      w = expected_words.pop_front();
      compare_field("selector_code", w.selector_code, tuser);
      compare_field("payload", w.payload, tdata[59:0]);
      compare_field("deltas_in_word", w.deltas_in_word, tdata[65:60]);
      compare_field("entry_total", w.entry_total, tdata[86:66]);
      compare_field("word_total", w.word_total, tdata[107:87]);
      compare_field("last_word", w.last_word, tlast);
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InTdataBits-1:0]  s_axis_tdata  = '0;
  logic                    s_axis_tlast  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutTdataBits-1:0] m_axis_tdata;
  logic [SelBits-1:0]      m_axis_tuser;
  logic                    m_axis_tlast;

  s8b_word_scoreboard sb = new();
  bit                 idle_on = 1'b1;
  int unsigned        indices_sent = 0;
  bit [31:0]          cursor;

  delta_simple8b_index_packer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Drive one index and return at the edge where the transaction completes.
  task automatic send_index(bit [31:0] column_index, bit last_index);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= column_index;
    s_axis_tlast  <= last_index;
    do @(negedge clk_i); while (s_axis_tready !== 1'b1);
    @(posedge clk_i);
    sb.note_index(column_index, last_index);
    indices_sent++;
  endtask

  // One column of random content; the style picks the step pattern.
  task automatic send_column(int unsigned len, int unsigned style);
    bit [31:0]   step;
    int unsigned w;
    if ($urandom_range(0, 2) == 0) begin
      cursor = $urandom;
    end else begin
      cursor = $urandom_range(0, 10);
    end
    for (int unsigned k = 0; k < len; k++) begin
      case (style)
        0: step = 32'd1;
        1: step = 32'd0;
        2: step = $urandom_range(1, 15);
        3: begin
          w    = $urandom_range(1, 32);
          step = ($urandom & (32'hFFFF_FFFF >> (32 - w))) + 32'd1;
        end
        default: step = $urandom;
      endcase
      if (k != 0 || style >= 4) begin
        cursor = (style >= 4) ? step : cursor + step;
      end
      send_index(cursor, k == len - 1);
    end
  endtask

  // Receiver with random stall bursts.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  end

  // Output words are sampled mid-cycle, ahead of the edge that accepts them.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
    end
  end

  initial begin
    #5ms;
    $display("delta_simple8b_index_packer: mismatch");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned style;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest index alone, then the widest possible first delta.
    send_index(32'h0000_0000, 1'b1);
    send_index(32'hFFFF_FFFF, 1'b1);
    // Repeated and falling indices give zero deltas; the jump forces a flush.
    send_index(32'd5, 1'b0);
    send_index(32'd5, 1'b0);
    send_index(32'd3, 1'b0);
    send_index(32'hFFFF_FFFF, 1'b0);
    send_index(32'hFFFF_FFFF, 1'b0);
    send_index(32'd0, 1'b1);
    // Deltas growing by one bit at a time.
    send_index(32'd0, 1'b0);
    send_index(32'd2, 1'b0);
    send_index(32'd6, 1'b0);
    send_index(32'd14, 1'b0);
    send_index(32'd30, 1'b0);
    send_index(32'd62, 1'b0);
    send_index(32'd126, 1'b0);
    send_index(32'd254, 1'b0);
    send_index(32'd255, 1'b1);
    // Two 30-bit deltas fill a word exactly; the third does not fit.
    send_index(32'h3FFF_FFFE, 1'b0);
    send_index(32'h7FFF_FFFD, 1'b0);
    send_index(32'h7FFF_FFFE, 1'b1);

    // Random columns, mostly well formed, some noise.
    while (indices_sent < 1050) begin
      if (indices_sent > 900) begin
        idle_on = 1'b0;
      end
      style = $urandom_range(0, 9);
      if (style >= 5) begin
        style = ($urandom_range(0, 1) == 0) ? 2 : 3;
      end
      if (style <= 1 && $urandom_range(0, 1) == 0) begin
        len = $urandom_range(55, 130);
      end else begin
        len = $urandom_range(1, 24);
      end
      send_column(len, style);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("delta_simple8b_index_packer: match");
    end else begin
      $display("delta_simple8b_index_packer: mismatch");
    end
    $finish;
  end

endmodule
